[rtl/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// shared types, constants and the re-arm function of the periodic timing wheel
// ----------------------------------------------------------------------------
package ptw_pkg;

	// wheel geometry, slot count is a power of two
	localparam int SLOT_BITS  = 3;
	localparam int SLOTS      = 1 << SLOT_BITS;

	// task table, one entry per 4-bit task id
	localparam int TASK_BITS  = 4;
	localparam int MAX_TASKS  = 16;
	localparam int PER_BITS   = 16;

	// command queue between front and back
	localparam int QUEUE_BITS  = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_BITS;

	// request codes on the input channel
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// classified operations carried by the queue
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [TASK_BITS-1:0] task_id;
		logic [PER_BITS-1:0]  period;
	} ptw_in_t;

	typedef struct packed {
		logic [TASK_BITS-1:0] expired_task;
		logic                 last_of_run;
	} ptw_out_t;

	typedef struct packed {
		logic [1:0]           op;
		logic [TASK_BITS-1:0] task_id;
		logic [PER_BITS-1:0]  period;
	} ptw_cmd_t;

	typedef struct packed {
		logic                 busy;
		logic [MAX_TASKS-1:0] fire_mask;
	} ptw_back_sts_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0] slot;
		logic [PER_BITS-1:0]  rounds;
	} ptw_arm_t;

	// slot = (period + pos) mod SLOTS, rounds = ceil(period / SLOTS) - 1, or 0 for a zero period
	function automatic ptw_arm_t ptw_arm(input logic [PER_BITS-1:0] period,
			input logic [SLOT_BITS-1:0] pos);
		ptw_arm_t             r;
		logic [PER_BITS-1:0]  pm1;
		pm1      = period - PER_BITS'(1);
		r.slot   = period[SLOT_BITS-1:0] + pos;
		r.rounds = (period == '0) ? '0 : (pm1 >> SLOT_BITS);
		return r;
	endfunction

endpackage

[rtl/ptw_front.sv]
// ----------------------------------------------------------------------------
// ptw_front
// accepts request items, classifies them and queues the ones that do work
// ----------------------------------------------------------------------------
module ptw_front import ptw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ptw_in_t  req,
	output logic     q_valid,
	input  logic     q_ready,
	output ptw_cmd_t q_cmd
);

	ptw_cmd_t               queue_q [QUEUE_DEPTH];
	logic [QUEUE_BITS-1:0]  wr_ptr_q;
	logic [QUEUE_BITS-1:0]  rd_ptr_q;
	logic [QUEUE_BITS:0]    count_q;
	ptw_cmd_t               cmd;
	logic                   id_ok;
	logic                   push;
	logic                   pop;

	// ids beyond the table are dropped here
	assign id_ok = ({1'b0, req.task_id} < (TASK_BITS + 1)'(MAX_TASKS));

	always_comb begin
		cmd.task_id = req.task_id;
		cmd.period  = req.period;
		unique case (req.req_type)
			REQ_ADD:    cmd.op = id_ok ? OP_ADD : OP_NONE;
			REQ_REMOVE: cmd.op = id_ok ? OP_REMOVE : OP_NONE;
			REQ_TICK:   cmd.op = OP_TICK;
			default:    cmd.op = OP_NONE;
		endcase
	end

	assign req_ready = (count_q != (QUEUE_BITS + 1)'(QUEUE_DEPTH));
	assign push      = req_valid && req_ready && (cmd.op != OP_NONE);
	assign q_valid   = (count_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_cmd     = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_BITS + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_BITS + 1)'(1);
			end
		end
	end

endmodule

[rtl/ptw_back.sv]
// ----------------------------------------------------------------------------
// ptw_back
// task table, wheel position, tick processing and expired-id emission
// ----------------------------------------------------------------------------
module ptw_back import ptw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  ptw_cmd_t      q_cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ptw_out_t      rsp,
	output ptw_back_sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic [0:0]           state_q;
	logic [MAX_TASKS-1:0] placed_q;
	logic [MAX_TASKS-1:0] pending_q;
	logic [PER_BITS-1:0]  period_q [MAX_TASKS];
	logic [SLOT_BITS-1:0] slot_q   [MAX_TASKS];
	logic [PER_BITS-1:0]  rounds_q [MAX_TASKS];
	logic [SLOT_BITS-1:0] pos_q;
	logic [MAX_TASKS-1:0] fire_q;
	logic                 out_valid_q;
	ptw_out_t             out_q;

	logic [SLOT_BITS-1:0] pos_next;
	logic [MAX_TASKS-1:0] hit;
	logic [MAX_TASKS-1:0] fire;
	ptw_arm_t             arm [MAX_TASKS];
	logic                 take;
	logic                 out_free;
	logic                 emit;
	logic [MAX_TASKS-1:0] low_bit;
	logic [TASK_BITS-1:0] low_idx;
	logic                 low_last;

	assign q_ready  = (state_q == ST_IDLE);
	assign take     = q_valid && q_ready;
	assign pos_next = pos_q + SLOT_BITS'(1);
	assign out_free = !out_valid_q || rsp_ready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	// slot match and expiry for every entry at the new position
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			hit[i]  = placed_q[i] && (slot_q[i] == pos_next);
			fire[i] = hit[i] && (rounds_q[i] == '0);
			arm[i]  = ptw_arm(period_q[i], pos_next);
		end
	end

	// lowest pending expiry goes out first
	assign low_bit  = fire_q & (~fire_q + MAX_TASKS'(1));
	assign low_last = ((fire_q & ~low_bit) == '0);

	always_comb begin
		low_idx = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (fire_q[i]) begin
				low_idx = TASK_BITS'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (q_cmd.op)
				OP_ADD: begin
					period_q[q_cmd.task_id] <= q_cmd.period;
				end
				OP_TICK: begin
					for (int i = 0; i < MAX_TASKS; i++) begin
						if (fire[i] || pending_q[i]) begin
							slot_q[i]   <= arm[i].slot;
							rounds_q[i] <= arm[i].rounds;
						end else if (hit[i]) begin
							rounds_q[i] <= rounds_q[i] - PER_BITS'(1);
						end
					end
				end
				default: ;
			endcase
		end
		if (emit) begin
			out_q.expired_task <= low_idx;
			out_q.last_of_run  <= low_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			placed_q    <= '0;
			pending_q   <= '0;
			pos_q       <= '0;
			fire_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (q_cmd.op)
							OP_ADD: begin
								pending_q[q_cmd.task_id] <= 1'b1;
								placed_q[q_cmd.task_id]  <= 1'b0;
							end
							OP_REMOVE: begin
								placed_q[q_cmd.task_id] <= 1'b0;
							end
							OP_TICK: begin
								pos_q     <= pos_next;
								placed_q  <= placed_q | pending_q;
								pending_q <= '0;
								fire_q    <= fire;
								if (fire != '0) begin
									state_q <= ST_EMIT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					if (emit) begin
						fire_q <= fire_q & ~low_bit;
						if (low_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp           = out_q;
	assign sts.busy      = (state_q == ST_EMIT);
	assign sts.fire_mask = fire_q;

endmodule

[rtl/periodic_timing_wheel_top.sv]
// ----------------------------------------------------------------------------
// periodic_timing_wheel_top
// hashed timing wheel with round counts for up to sixteen periodic tasks
// ----------------------------------------------------------------------------
// an add or remove waits in the command queue and takes effect when the back takes it;
//   a tick's expired ids are offered through the registered output stage
// throughput: one add or remove per cycle while the back end is idle; a tick that
//   fires holds it until its ids are out, one per cycle while the output is free
// reset: arst_n clears task flags, wheel position, command queue and output
module periodic_timing_wheel_top import ptw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ptw_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ptw_out_t rsp
);

	// classified commands between the front and the back
	logic          q_valid;
	logic          q_ready;
	ptw_cmd_t      q_cmd;
	ptw_back_sts_t back_sts;

	// front: takes every request item, drops unknown codes and bad ids,
	// keeps up to four commands so the input side runs ahead of a long tick
	ptw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd)
	);

	// back: applies each add or remove, or a tick update of the whole table,
	// then sends one expired id per cycle in ascending order while the output
	// register is free
	ptw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.sts       (back_sts)
	);

`ifndef SYNTHESIS
	// the queue never carries a dropped request
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (q_cmd.op != OP_NONE))
		else $error("queue holds a dropped request");

	// while emitting there is always an expired task left to send
	assert property (@(posedge clk) disable iff (!arst_n)
		back_sts.busy |-> (back_sts.fire_mask != '0))
		else $error("emitting with no expired task");

	// an item that is not the last of its run is followed at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && !rsp.last_of_run) |=> rsp_valid)
		else $error("run of expired items broken");

	// no new command is taken while a run is being emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		back_sts.busy |-> !q_ready)
		else $error("command taken during emission");
`endif

endmodule

[verif/periodic_timing_wheel_top_test.sv]
// ----------------------------------------------------------------------------
// periodic_timing_wheel_top_test
// self-checking testbench for the periodic timing wheel
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a clocked driver on the request channel.
// every accepted request also updates a local copy of the wheel, and that copy
// works out which task ids expire on each tick. a clocked monitor on the
// response channel checks each expired id against the oldest one predicted.
// both channels stall at random, except in one stretch with no stalls.
// ----------------------------------------------------------------------------
module periodic_timing_wheel_top_test import ptw_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int IDLE_PCT   = 19;
	// cycles to let the back end settle once nothing is expected
	localparam int SETTLE_CYCLES = 24;
	// request code with no meaning
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	ptw_in_t  req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	ptw_out_t rsp;

	// requests waiting for the driver, expired ids waiting for the monitor
	ptw_in_t  pending_reqs[$];
	ptw_out_t due_expiries[$];

	// no random stalls on either side while set
	logic steady = 1'b0;
	int   err_count = 0;

	// local copy of the wheel
	logic                 on_wheel[MAX_TASKS];
	logic                 waiting[MAX_TASKS];
	logic [PER_BITS-1:0]  per_tbl[MAX_TASKS];
	logic [SLOT_BITS-1:0] slot_tbl[MAX_TASKS];
	logic [PER_BITS-1:0]  rounds_tbl[MAX_TASKS];
	logic [SLOT_BITS-1:0] cur_slot = '0;

	initial begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			on_wheel[i] = 1'b0;
			waiting[i]  = 1'b0;
		end
	end

	periodic_timing_wheel_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// append a request to the driver's queue
	function automatic void enqueue_req(ptw_in_t r);
		pending_reqs = {pending_reqs, r};
	endfunction

	// put a task one period ahead of the current slot
	function automatic void arm_entry(int id);
		logic [PER_BITS-1:0] p;
		p = per_tbl[id];
		slot_tbl[id]   = p[SLOT_BITS-1:0] + cur_slot;
		// ceil(p / SLOTS) - 1 rounds; zero period means zero rounds
		rounds_tbl[id] = (p == '0) ? '0 : ((p - 1'b1) >> SLOT_BITS);
		on_wheel[id]   = 1'b1;
	endfunction

	// apply one accepted request to the local wheel and queue the expiries
	function automatic void predict_expiries(ptw_in_t item);
		logic [TASK_BITS-1:0] hits[$];
		ptw_out_t             hit;
		case (item.req_type)
			REQ_ADD: begin
				// re-add overwrites the period and drops any placement
				per_tbl[item.task_id]  = item.period;
				waiting[item.task_id]  = 1'b1;
				on_wheel[item.task_id] = 1'b0;
			end
			REQ_REMOVE: begin
				// a pending task stays pending
				on_wheel[item.task_id] = 1'b0;
			end
			REQ_TICK: begin
				cur_slot = cur_slot + 1'b1;
				// each entry looked at once, even if re-armed into this slot
				for (int i = 0; i < MAX_TASKS; i++) begin
					if (on_wheel[i] && slot_tbl[i] == cur_slot) begin
						if (rounds_tbl[i] == '0) begin
							hits = {hits, TASK_BITS'(i)};
							arm_entry(i);
						end else begin
							rounds_tbl[i] = rounds_tbl[i] - 1'b1;
						end
					end
				end
				for (int k = 0; k < hits.size(); k++) begin
					hit.expired_task = hits[k];
					hit.last_of_run  = (k == hits.size() - 1);
					due_expiries = {due_expiries, hit};
				end
				// pending tasks go on relative to the new position
				for (int i = 0; i < MAX_TASKS; i++) begin
					if (waiting[i]) begin
						waiting[i] = 1'b0;
						arm_entry(i);
					end
				end
			end
			default: begin
				// unknown request code does nothing
			end
		endcase
	endfunction

	function automatic ptw_in_t make_req(logic [1:0] kind, int id, int per);
		ptw_in_t r;
		r.req_type = kind;
		r.task_id  = TASK_BITS'(id);
		r.period   = PER_BITS'(per);
		return r;
	endfunction

	// random request, weighted toward ticks and short periods so tasks fire often
	function automatic ptw_in_t rand_req();
		ptw_in_t r;
		int      pick;
		int      span;
		pick = $urandom_range(99);
		span = $urandom_range(99);
		r.task_id = TASK_BITS'($urandom_range(MAX_TASKS - 1));
		r.period  = PER_BITS'($urandom);
		if (pick < 40) begin
			r.req_type = REQ_TICK;
		end else if (pick < 95) begin
			r.req_type = (pick < 82) ? REQ_ADD : REQ_REMOVE;
			if (r.req_type == REQ_ADD) begin
				if (span < 60)
					r.period = PER_BITS'($urandom_range(1, 12));
				else if (span < 75)
					r.period = PER_BITS'(SLOTS * $urandom_range(1, 3));
				else if (span < 87)
					r.period = PER_BITS'($urandom_range(13, 40));
				else if (span < 93)
					r.period = '0;
			end
		end else begin
			// unused request code
			r.req_type = REQ_UNUSED;
		end
		return r;
	endfunction

	// request driver: valid holds with a stable payload until accepted
	always @(posedge clk or negedge arst_n) begin : req_drive
		logic nxt_valid;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			nxt_valid = req_valid;
			if (req_valid && req_ready) begin
				predict_expiries(req);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_reqs.size() != 0 &&
					(steady || $urandom_range(99) >= IDLE_PCT)) begin
				req       <= pending_reqs.pop_front();
				nxt_valid = 1'b1;
			end
			req_valid <= nxt_valid;
		end
	end

	// response monitor: every expired id is checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : rsp_check
		ptw_out_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_expiries.size() == 0) begin
					$display("%0t: unexpected item expired_task expected none actual %0d",
						$time, rsp.expired_task);
					err_count++;
				end else begin
					want = due_expiries.pop_front();
					if (rsp.expired_task !== want.expired_task) begin
						$display("%0t: expired_task expected %0d actual %0d",
							$time, want.expired_task, rsp.expired_task);
						err_count++;
					end
					if (rsp.last_of_run !== want.last_of_run) begin
						$display("%0t: last_of_run expected %0d actual %0d",
							$time, want.last_of_run, rsp.last_of_run);
						err_count++;
					end
				end
			end
			rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("[periodic_timing_wheel_top] ERROR");
		$finish;
	end

	// stimulus and end of run
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: period extremes, all request codes and the special cases
		enqueue_req(make_req(REQ_ADD, 0, 1));
		enqueue_req(make_req(REQ_ADD, 15, 0));      // zero period
		enqueue_req(make_req(REQ_ADD, 5, SLOTS));   // fires on time, same slot
		enqueue_req(make_req(REQ_ADD, 10, 16'hffff));
		enqueue_req(make_req(REQ_ADD, 3, SLOTS + 1));
		enqueue_req(make_req(REQ_TICK, 0, 0));
		enqueue_req(make_req(REQ_TICK, 15, 16'hffff));
		enqueue_req(make_req(REQ_REMOVE, 7, 0));    // absent task
		enqueue_req(make_req(REQ_ADD, 6, 2));
		enqueue_req(make_req(REQ_REMOVE, 6, 0));    // pending stays pending
		enqueue_req(make_req(REQ_UNUSED, 9, 16'h5a5a));
		enqueue_req(make_req(REQ_ADD, 0, 3));       // re-add of a placed task
		enqueue_req(make_req(REQ_ADD, 12, 4));
		enqueue_req(make_req(REQ_TICK, 0, 0));
		enqueue_req(make_req(REQ_REMOVE, 12, 0));   // placed task dropped
		for (int i = 0; i < 10; i++)
			enqueue_req(make_req(REQ_TICK, i, 0));

		// hold the sender until every predicted expiry has come out
		while (pending_reqs.size() != 0 || req_valid || due_expiries.size() != 0)
			@(posedge clk);

		for (int i = 0; i < 100; i++)
			enqueue_req(rand_req());
		while (pending_reqs.size() != 0)
			@(posedge clk);

		// stretch with no stalls on either side
		steady <= 1'b1;
		for (int i = 0; i < 60; i++)
			enqueue_req(rand_req());
		while (pending_reqs.size() != 0)
			@(posedge clk);
		steady <= 1'b0;

		for (int i = 0; i < 75; i++)
			enqueue_req(rand_req());

		while (pending_reqs.size() != 0 || req_valid || due_expiries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("[periodic_timing_wheel_top] OK");
		else
			$display("[periodic_timing_wheel_top] ERROR");
		$finish;
	end

endmodule

[periodic_timing_wheel_top.f]
rtl/ptw_pkg.sv
rtl/ptw_front.sv
rtl/ptw_back.sv
rtl/periodic_timing_wheel_top.sv
verif/periodic_timing_wheel_top_test.sv
